### hw/rtl/necir_pkg.sv
// Shared types and timing constants for the NEC infrared pulse decoder.
`timescale 1ns / 1ps

package necir_pkg;

    typedef enum logic [1:0] {
        KIND_FALL    = 2'd0,
        KIND_RISE    = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_TAKE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LEADER = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]  frame_phase;
        logic [5:0]  message_count;
        logic [31:0] message;
    } result_t;

    localparam logic [15:0] T_RESYNC_MIN   = 16'd30000;
    localparam logic [15:0] T_REPEAT_LO    = 16'd2000;
    localparam logic [15:0] T_REPEAT_HI    = 16'd2500;
    localparam logic [15:0] T_HEADER_LO    = 16'd4000;
    localparam logic [15:0] T_HEADER_HI    = 16'd5000;
    localparam logic [15:0] T_BIT_LO       = 16'd400;
    localparam logic [15:0] T_BIT_HI       = 16'd1880;
    localparam logic [15:0] T_GAP_LO       = 16'd800;
    localparam logic [15:0] T_GAP_HI       = 16'd1400;
    localparam logic [15:0] T_ONE_MIN      = 16'd1000;
    localparam logic [15:0] T_RISE_MAX     = 16'd11000;
    localparam logic [15:0] T_MARK_LO      = 16'd300;
    localparam logic [15:0] T_MARK_HI      = 16'd950;
    localparam logic [15:0] T_TIMEOUT_MAX  = 16'd10000;
    localparam logic [31:0] REPEAT_WINDOW  = 32'd262144;
    localparam logic [5:0]  FRAME_BITS     = 6'd32;
    localparam logic [5:0]  COUNT_NONE     = 6'd0;
    localparam logic [5:0]  COUNT_REPEAT   = 6'd1;
    localparam logic [31:0] REPEAT_MESSAGE = 32'd1;

endpackage

### hw/rtl/necir_core.sv
// Frame state registers and the per-event decode logic.
`timescale 1ns / 1ps

module necir_core import necir_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  logic [1:0]  kind,
    input  logic [31:0] elapsed_long,
    input  logic [15:0] elapsed_short,
    output result_t     result
);

    logic [31:0] time_sum_reg, time_sum_next;
    logic [31:0] last_time_reg, last_time_next;
    phase_t      phase_reg, phase_next;
    logic [5:0]  bits_reg, bits_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] held_msg_reg, held_msg_next;
    logic [5:0]  held_cnt_reg, held_cnt_next;

    logic [31:0] sum_new;
    logic [31:0] since_last;
    logic [31:0] shift_bit;
    logic [31:0] shift_upd;
    logic [5:0]  bits_inc;
    logic [15:0] t;

    assign t          = elapsed_short;
    assign sum_new    = time_sum_reg + elapsed_long;
    assign since_last = sum_new - last_time_reg;
    assign shift_bit  = 32'h8000_0000 >> bits_reg[4:0];
    assign shift_upd  = (t > T_ONE_MIN) ? (shift_reg | shift_bit) : shift_reg;
    assign bits_inc   = bits_reg + 6'd1;

    always_comb begin
        time_sum_next  = time_sum_reg;
        last_time_next = last_time_reg;
        phase_next     = phase_reg;
        bits_next      = bits_reg;
        shift_next     = shift_reg;
        held_msg_next  = held_msg_reg;
        held_cnt_next  = held_cnt_reg;
        unique case (kind_t'(kind))
            KIND_TAKE: begin
                held_cnt_next = COUNT_NONE;
            end
            KIND_FALL: begin
                time_sum_next = sum_new;
                if (phase_reg == PH_IDLE || t >= T_RESYNC_MIN) begin
                    phase_next = PH_LEADER;
                    bits_next  = 6'd0;
                end else if (phase_reg == PH_LEADER) begin
                    if (t > T_REPEAT_LO && t < T_REPEAT_HI) begin
                        if (last_time_reg != 32'd0) begin
                            if (since_last < REPEAT_WINDOW) begin
                                if (held_cnt_reg == COUNT_NONE) begin
                                    held_cnt_next = COUNT_REPEAT;
                                    held_msg_next = REPEAT_MESSAGE;
                                end
                                last_time_next = sum_new;
                            end else begin
                                last_time_next = 32'd0;
                            end
                        end
                    end else if (t < T_HEADER_LO || t > T_HEADER_HI) begin
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_DATA;
                        shift_next = 32'd0;
                    end
                end else if (phase_reg != PH_DATA) begin
                    phase_next = PH_IDLE;
                end else if (t < T_BIT_LO || t > T_BIT_HI) begin
                    phase_next = PH_IDLE;
                end else if (t > T_GAP_LO && t < T_GAP_HI) begin
                    phase_next = PH_IDLE;
                end else if (bits_reg < FRAME_BITS) begin
                    shift_next = shift_upd;
                    bits_next  = bits_inc;
                    if (bits_inc == FRAME_BITS) begin
                        held_msg_next  = shift_upd;
                        last_time_next = sum_new;
                        shift_next     = 32'd0;
                        held_cnt_next  = FRAME_BITS;
                        phase_next     = PH_IDLE;
                    end
                end
            end
            KIND_RISE: begin
                time_sum_next = sum_new;
                if (t > T_RISE_MAX) begin
                    phase_next = PH_IDLE;
                end else if (phase_reg == PH_DATA && (t < T_MARK_LO || t > T_MARK_HI)) begin
                    phase_next = PH_IDLE;
                end
            end
            KIND_TIMEOUT: begin
                time_sum_next = sum_new;
                if (t > T_TIMEOUT_MAX) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                held_cnt_next = held_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_sum_reg  <= 32'd0;
            last_time_reg <= 32'd0;
            phase_reg     <= PH_IDLE;
            bits_reg      <= 6'd0;
            shift_reg     <= 32'd0;
            held_msg_reg  <= 32'd0;
            held_cnt_reg  <= COUNT_NONE;
        end else if (step_en) begin
            time_sum_reg  <= time_sum_next;
            last_time_reg <= last_time_next;
            phase_reg     <= phase_next;
            bits_reg      <= bits_next;
            shift_reg     <= shift_next;
            held_msg_reg  <= held_msg_next;
            held_cnt_reg  <= held_cnt_next;
        end
    end

    assign result.message       = held_msg_next;
    assign result.message_count = held_cnt_next;
    assign result.frame_phase   = phase_next;

endmodule

### hw/rtl/nec_ir_pulse_decoder_unit.sv
// Top level of the NEC infrared pulse decoder with input and result registers.
`timescale 1ns / 1ps

// Decodes NEC infrared frames from a stream of timed edge events, one event per
// transfer, and returns one result per event: the held message, its count (0 none
// pending, 1 repeat, 32 full message) and the frame phase after that event. An
// event is registered on entry, decoded against the frame state and registered
// again on the result side, so an event can be taken in every cycle; its result
// passes through the input and result registers before it is presented. The rate
// of one event per cycle holds while the result side is not stalled; a stalled
// result side holds both stages and throttles the input through s_tready.

module nec_ir_pulse_decoder_unit import necir_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // elapsed_long[31:0], elapsed_short[47:32]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // message[31:0], message_count[37:32], frame_phase[39:38]
);

    logic        in_valid_reg;
    logic [1:0]  in_kind_reg;
    logic [31:0] in_long_reg;
    logic [15:0] in_short_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     core_result;
    logic        out_free;
    logic        advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg  <= s_tuser;
            in_long_reg  <= s_tdata[31:0];
            in_short_reg <= s_tdata[47:32];
        end
    end

    necir_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .kind          (in_kind_reg),
        .elapsed_long  (in_long_reg),
        .elapsed_short (in_short_reg),
        .result        (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

### tb/sv/tb_nec_ir_pulse_decoder_unit.sv
// Self-checking testbench for the NEC infrared pulse decoder with random stalls on both sides.
`timescale 1ns / 1ps

module tb_nec_ir_pulse_decoder_unit;
    import necir_pkg::*;

    typedef struct {
        kind_t       kind;
        logic [31:0] el;
        logic [15:0] t;
        bit          drain;
    } ir_event_t;

    localparam int NUM_EVENTS  = 1400;
    localparam int STALL_PCT   = 38;
    localparam int QUIET_LO    = 400;
    localparam int QUIET_HI    = 700;
    localparam int FRAME_EDGES = 67;
    localparam int HANG_LIMIT  = 5000;
    localparam int SETTLE      = 8;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    ir_event_t   pending_events[$];
    result_t     expected_results[$];
    logic [31:0] gen_sum = '0;

    logic [31:0] sum_time;
    logic [31:0] last_msg_time;
    phase_t      cur_phase;
    logic [5:0]  bit_count;
    logic [31:0] shift_reg;
    logic [31:0] held_msg;
    logic [5:0]  held_cnt;

    int          errors      = 0;
    int          sent_cnt    = 0;
    int          result_cnt  = 0;
    int          idle_cycles = 0;
    ir_event_t   next_ev;
    result_t     got;
    result_t     want;

    nec_ir_pulse_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // elapsed_long[31:0], elapsed_short[47:32]
        .s_tuser  (s_tuser),   // kind[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // message[31:0], message_count[37:32], frame_phase[39:38]
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic decode_fall(input logic [15:0] t);
        logic [31:0] since_msg;
        since_msg = sum_time - last_msg_time;
        if (cur_phase == PH_IDLE || t >= T_RESYNC_MIN) begin
            cur_phase = PH_LEADER;
            bit_count = '0;
        end else if (cur_phase == PH_LEADER) begin
            if (t > T_REPEAT_LO && t < T_REPEAT_HI) begin
                if (last_msg_time != '0) begin
                    if (since_msg < REPEAT_WINDOW) begin
                        if (held_cnt == COUNT_NONE) begin
                            held_cnt = COUNT_REPEAT;
                            held_msg = REPEAT_MESSAGE;
                        end
                        last_msg_time = sum_time;
                    end else begin
                        last_msg_time = '0;
                    end
                end
            end else if (t < T_HEADER_LO || t > T_HEADER_HI) begin
                cur_phase = PH_IDLE;
            end else begin
                cur_phase = PH_DATA;
                shift_reg = '0;
            end
        end else if (cur_phase != PH_DATA) begin
            cur_phase = PH_IDLE;
        end else if (t < T_BIT_LO || t > T_BIT_HI || (t > T_GAP_LO && t < T_GAP_HI)) begin
            cur_phase = PH_IDLE;
        end else if (bit_count < FRAME_BITS) begin
            if (t > T_ONE_MIN)
                shift_reg = shift_reg | (32'h8000_0000 >> bit_count);
            bit_count = bit_count + 6'd1;
            if (bit_count == FRAME_BITS) begin
                held_msg      = shift_reg;
                last_msg_time = sum_time;
                shift_reg     = '0;
                held_cnt      = FRAME_BITS;
                cur_phase     = PH_IDLE;
            end
        end
    endtask

    task automatic decode_event(input kind_t k, input logic [31:0] el, input logic [15:0] t);
        result_t r;
        if (k == KIND_TAKE) begin
            held_cnt = COUNT_NONE;
        end else begin
            sum_time = sum_time + el;
            case (k)
                KIND_FALL: begin
                    decode_fall(t);
                end
                KIND_RISE: begin
                    if (t > T_RISE_MAX)
                        cur_phase = PH_IDLE;
                    if (cur_phase == PH_DATA && (t < T_MARK_LO || t > T_MARK_HI))
                        cur_phase = PH_IDLE;
                end
                default: begin
                    if (t > T_TIMEOUT_MAX)
                        cur_phase = PH_IDLE;
                end
            endcase
        end
        r.message       = held_msg;
        r.message_count = held_cnt;
        r.frame_phase   = cur_phase;
        expected_results.push_back(r);
    endtask

    task automatic add_event(input kind_t k, input logic [31:0] el, input logic [15:0] t);
        ir_event_t ev;
        ev.kind  = k;
        ev.el    = el;
        ev.t     = t;
        ev.drain = 1'b0;
        if (k != KIND_TAKE)
            gen_sum = gen_sum + el;
        pending_events.push_back(ev);
    endtask

    initial begin
        int          sel;
        int          cut;
        int          bit_idx;
        bit          wrap;
        logic [31:0] word;
        logic [31:0] el;
        logic [15:0] t;
        kind_t       k;

        sum_time      = '0;
        last_msg_time = '0;
        cur_phase     = PH_IDLE;
        bit_count     = '0;
        shift_reg     = '0;
        held_msg      = '0;
        held_cnt      = '0;

        add_event(KIND_TAKE,    32'hFFFF_FFFF, 16'hFFFF);
        add_event(KIND_FALL,    32'h0,         16'h0);
        add_event(KIND_FALL,    32'h0,         16'hFFFF);
        add_event(KIND_FALL,    32'h10,        16'd2001);
        add_event(KIND_FALL,    32'h10,        16'd3999);
        add_event(KIND_FALL,    32'h10,        16'd0);
        add_event(KIND_FALL,    32'h10,        16'd4000);
        add_event(KIND_RISE,    32'h10,        16'd299);
        add_event(KIND_FALL,    32'h10,        16'd100);
        add_event(KIND_FALL,    32'h10,        16'd5000);
        add_event(KIND_RISE,    32'h10,        16'd950);
        add_event(KIND_RISE,    32'h10,        16'd300);
        add_event(KIND_FALL,    32'h10,        16'd400);
        add_event(KIND_FALL,    32'h10,        16'd1880);
        add_event(KIND_FALL,    32'h10,        16'd1000);
        add_event(KIND_FALL,    32'hFFFF_FFFF, 16'd30000);
        add_event(KIND_FALL,    32'h0,         16'd4500);
        add_event(KIND_TIMEOUT, 32'h5555_5555, 16'd10000);
        add_event(KIND_FALL,    32'hAAAA_AAAA, 16'd1881);
        add_event(KIND_RISE,    32'h1,         16'd11001);
        add_event(KIND_FALL,    32'h1,         16'd2500);
        add_event(KIND_TIMEOUT, 32'h1,         16'd10001);
        add_event(KIND_RISE,    32'h1,         16'd11000);

        // The first random event waits until the directed part has fully drained.
        while (pending_events.size() < NUM_EVENTS) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                // Well-formed frames, or broken ones with a noise event at a random edge.
                cut  = (sel < 30) ? FRAME_EDGES : $urandom_range(FRAME_EDGES - 1);
                word = $urandom;
                wrap = ($urandom_range(7) == 0);
                for (int n = 0; n < FRAME_EDGES; n++) begin
                    if (n == cut) begin
                        add_event(kind_t'($urandom_range(3)), $urandom,
                                  16'($urandom_range(16'hFFFF)));
                        break;
                    end
                    if (n == 0) begin
                        k = KIND_FALL;
                        t = 16'($urandom_range(16'hFFFF, 30000));
                    end else if (n == 1) begin
                        k = KIND_RISE;
                        t = 16'($urandom_range(9500, 8000));
                    end else if (n == 2) begin
                        k = KIND_FALL;
                        t = 16'($urandom_range(T_HEADER_HI, T_HEADER_LO));
                    end else if (n % 2 == 1) begin
                        k = KIND_RISE;
                        t = 16'($urandom_range(T_MARK_HI, T_MARK_LO));
                    end else begin
                        bit_idx = 31 - (n - 4) / 2;
                        k = KIND_FALL;
                        t = word[bit_idx] ? 16'($urandom_range(T_BIT_HI, T_GAP_HI))
                                          : 16'($urandom_range(T_GAP_LO, T_BIT_LO));
                    end
                    el = ($urandom_range(9) == 0) ? $urandom : {16'h0, t};
                    // Land the running sum on zero when the word is posted.
                    if (n == FRAME_EDGES - 1 && wrap)
                        el = 32'h0 - gen_sum;
                    add_event(k, el, t);
                end
            end else if (sel < 70) begin
                el = ($urandom_range(5) == 0) ? $urandom : $urandom_range(3000);
                add_event(KIND_FALL, el, 16'($urandom_range(16'hFFFF, 30000)));
                add_event(KIND_RISE, $urandom_range(3000), 16'($urandom_range(9500, 8000)));
                add_event(KIND_FALL, $urandom_range(3000),
                          16'($urandom_range(T_REPEAT_HI, T_REPEAT_LO)));
                if ($urandom_range(1) == 0)
                    add_event(KIND_TIMEOUT, $urandom_range(3000),
                              16'($urandom_range(16'hFFFF, T_TIMEOUT_MAX + 1)));
            end else if (sel < 82) begin
                add_event(KIND_TAKE, $urandom, 16'($urandom_range(16'hFFFF)));
            end else begin
                add_event(kind_t'($urandom_range(3)), $urandom,
                          16'($urandom_range(16'hFFFF)));
            end
        end
        pending_events[23].drain = 1'b1;
        pending_events[NUM_EVENTS / 2].drain = 1'b1;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_events.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_event(kind_t'(s_tuser), s_tdata[31:0], s_tdata[47:32]);
                sent_cnt <= sent_cnt + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_events.size() != 0
                        && !(pending_events[0].drain && expected_results.size() != 0)
                        && ((sent_cnt >= QUIET_LO && sent_cnt < QUIET_HI)
                            || $urandom_range(99) >= STALL_PCT)) begin
                    next_ev = pending_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_ev.t, next_ev.el};
                    s_tuser  <= next_ev.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                result_cnt <= result_cnt + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.message !== want.message) begin
                        $display("%0t: message expected %h actual %h",
                                 $time, want.message, got.message);
                        errors++;
                    end
                    if (got.message_count !== want.message_count) begin
                        $display("%0t: message_count expected %0d actual %0d",
                                 $time, want.message_count, got.message_count);
                        errors++;
                    end
                    if (got.frame_phase !== want.frame_phase) begin
                        $display("%0t: frame_phase expected %0d actual %0d",
                                 $time, want.frame_phase, got.frame_phase);
                        errors++;
                    end
                end
            end
            m_tready <= (result_cnt >= QUIET_LO && result_cnt < QUIET_HI)
                        || $urandom_range(99) >= STALL_PCT;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
